// File: rtl/pwp_pkg.sv
// shared widths, fixed-point constants and the side-payload type of the preconditioner
// no dependencies
package pwp_pkg;

  localparam int GW      = 24;            // reciprocal vector component width
  localparam int XIW     = 32;            // residual part width
  localparam int TW      = 32;            // kinetic energy width
  localparam int FRAC    = 16;            // fraction bits of x and of the weight
  localparam int XW      = 24;            // x width, unsigned Q8.16
  localparam int X_SHIFT = 7;             // x = g2 * 2^7 / t
  localparam int SAT_SH  = XW - X_SHIFT;  // x saturates when g2 >= t * 2^17
  localparam int G2W     = 2 * GW;        // |g|^2 width
  localparam int X2W     = 2 * XW - FRAC;
  localparam int X3W     = X2W + XW - FRAC;
  localparam int X4W     = X3W + XW - FRAC;
  localparam int NUMW    = X3W + 4;
  localparam int DENW    = X4W + 5;
  localparam int WW      = FRAC + 1;      // weight, 1..65536
  localparam int DVW     = NUMW + FRAC + 1;

  localparam logic [XW-1:0]   X_MAX   = '1;
  localparam logic [NUMW-1:0] C27_Q   = NUMW'(27) << FRAC;
  localparam logic [NUMW-1:0] K18     = NUMW'(18);
  localparam logic [NUMW-1:0] K12     = NUMW'(12);
  localparam logic [NUMW-1:0] K8      = NUMW'(8);
  localparam logic [XIW+WW-1:0] RND_HALF = (XIW+WW)'(1) << (FRAC - 1);

  typedef struct packed {
    logic [XIW-1:0] mre;
    logic [XIW-1:0] mim;
    logic           sre;
    logic           sim;
    logic           last;
  } side_t;

endpackage

// File: rtl/plane_wave_preconditioner.sv
// plane-wave residual preconditioner with the teter-payne-allan rational weight
// depends on pwp_pkg for widths, constants and the side-payload type
//
// Takes one beat per cycle unless the master side stalls, and returns one beat per input
// beat, in order. The two restoring dividers make up most of the pipeline: one stage per
// quotient bit, 24 for x = |G|^2 / (2T) and 17 for the weight. A stall on the master side
// halts the whole pipeline and drops nothing. kinetic_energy is read live by the pipeline,
// so write it only while no beat is in flight.
module plane_wave_preconditioner
  import pwp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [3*GW+2*XIW-1:0] s_axis_tdata,   // gx, gy, gz, xi_re, xi_im
  input  logic                  s_axis_tlast,   // last_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*XIW-1:0]      m_axis_tdata,   // eta_re, eta_im
  output logic                  m_axis_tlast,   // last_out
  input  logic                  cfg_wr_en,
  input  logic [TW-1:0]         cfg_wr_data     // kinetic_energy
);

  localparam int S_IN  = 0;
  localparam int S_SQ  = 1;
  localparam int S_G2  = 2;
  localparam int S_D1  = 3;
  localparam int S_X   = S_D1 + XW + 1;
  localparam int S_X2  = S_X + 1;
  localparam int S_X3  = S_X2 + 1;
  localparam int S_X4  = S_X3 + 1;
  localparam int S_DEN = S_X4 + 1;
  localparam int S_D2  = S_DEN + 1;
  localparam int S_PR  = S_D2 + WW + 1;
  localparam int S_OUT = S_PR + 1;
  localparam int NST   = S_OUT + 1;

  logic [TW-1:0]  kinetic_energy;
  logic [NST-1:0] vld;
  side_t          side [NST];
  logic           adv;

  logic [GW-1:0]  gx, gy, gz;
  logic [XIW-1:0] xi_re, xi_im;
  logic [GW-1:0]  ax, ay, az;
  logic [G2W-1:0] sq_x, sq_y, sq_z;
  logic [G2W-1:0] g2;

  logic [TW-1:0]  r1  [XW+1];
  logic [XW-1:0]  lo1 [XW+1];
  logic [XW-1:0]  q1  [XW+1];
  logic           sat [XW+1];

  logic [XW-1:0]    xq, xq2, xq3;
  logic [X2W-1:0]   x2, x2b;
  logic [X3W-1:0]   x3;
  logic [X4W-1:0]   x4;
  logic [NUMW-1:0]  num, num_c, num_d;
  logic [DENW-1:0]  den;
  logic [2*XW-1:0]  p2;
  logic [X2W+XW-1:0] p3;
  logic [X3W+XW-1:0] p4;
  logic [DVW-1:0]   dvd;

  logic [DENW-1:0]  r2  [WW+1];
  logic [WW-1:0]    lo2 [WW+1];
  logic [WW-1:0]    q2  [WW+1];
  logic [DENW-1:0]  dn  [WW+1];

  logic [XIW+WW-1:0] pr_re, pr_im, rn_re, rn_im;
  logic [XIW-1:0]    mag_re, mag_im, eta_re, eta_im;

  assign {xi_im, xi_re, gz, gy, gx} = s_axis_tdata;

  assign adv           = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = {eta_im, eta_re};
  assign m_axis_tlast  = side[NST-1].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      kinetic_energy <= TW'(65536);
    end else if (cfg_wr_en) begin
      kinetic_energy <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // residual magnitudes and signs travel alongside
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].mre  <= xi_re[XIW-1] ? XIW'(-xi_re) : xi_re;
      side[0].mim  <= xi_im[XIW-1] ? XIW'(-xi_im) : xi_im;
      side[0].sre  <= xi_re[XIW-1];
      side[0].sim  <= xi_im[XIW-1];
      side[0].last <= s_axis_tlast;
      for (int k = 1; k < NST; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // |G|^2, the saturation flag and the x divider inputs
  always_ff @(posedge clk) begin
    if (adv) begin
      ax   <= gx[GW-1] ? GW'(-gx) : gx;
      ay   <= gy[GW-1] ? GW'(-gy) : gy;
      az   <= gz[GW-1] ? GW'(-gz) : gz;
      sq_x <= ax * ax;
      sq_y <= ay * ay;
      sq_z <= az * az;
      g2   <= sq_x + sq_y + sq_z;
      sat[0] <= {1'b0, g2} >= {kinetic_energy, SAT_SH'(0)};
      r1[0]  <= TW'(g2[G2W-1:SAT_SH]);
      lo1[0] <= {g2[SAT_SH-1:0], X_SHIFT'(0)};
      q1[0]  <= '0;
    end
  end

  // x divider, one quotient bit per stage
  for (genvar k = 0; k < XW; k++) begin : g_div1
    logic [TW:0] t;
    logic        ge;
    assign t  = {r1[k], lo1[k][XW-1]};
    assign ge = t >= {1'b0, kinetic_energy};
    always_ff @(posedge clk) begin
      if (adv) begin
        r1[k+1]  <= ge ? TW'(t - {1'b0, kinetic_energy}) : t[TW-1:0];
        lo1[k+1] <= {lo1[k][XW-2:0], 1'b0};
        q1[k+1]  <= {q1[k][XW-2:0], ge};
        sat[k+1] <= sat[k];
      end
    end
  end

  // powers of x and the rational weight terms
  assign p2    = xq * xq;
  assign p3    = x2 * xq2;
  assign p4    = x3 * xq3;
  assign num_c = C27_Q + NUMW'(xq3) * K18 + NUMW'(x2b) * K12 + NUMW'(x3) * K8;

  always_ff @(posedge clk) begin
    if (adv) begin
      xq  <= sat[XW] ? X_MAX : q1[XW];
      x2  <= p2[2*XW-1:FRAC];
      xq2 <= xq;
      x3  <= p3[X2W+XW-1:FRAC];
      x2b <= x2;
      xq3 <= xq2;
      x4  <= p4[X3W+XW-1:FRAC];
      num <= num_c;
      den <= DENW'(num) + {x4, 4'b0};
    end
  end

  assign dvd = (DVW'(num_d) << FRAC) + DVW'(den >> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      r2[0]  <= DENW'(dvd[DVW-1:WW]);
      lo2[0] <= dvd[WW-1:0];
      q2[0]  <= '0;
      dn[0]  <= den;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_d <= num;
    end
  end

  // weight divider, one quotient bit per stage
  for (genvar k = 0; k < WW; k++) begin : g_div2
    logic [DENW:0] t;
    logic          ge;
    assign t  = {r2[k], lo2[k][WW-1]};
    assign ge = t >= {1'b0, dn[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        r2[k+1]  <= ge ? DENW'(t - {1'b0, dn[k]}) : t[DENW-1:0];
        lo2[k+1] <= {lo2[k][WW-2:0], 1'b0};
        q2[k+1]  <= {q2[k][WW-2:0], ge};
        dn[k+1]  <= dn[k];
      end
    end
  end

  // scale, round half away from zero, restore sign
  assign rn_re  = pr_re + RND_HALF;
  assign rn_im  = pr_im + RND_HALF;
  assign mag_re = rn_re[FRAC+XIW-1:FRAC];
  assign mag_im = rn_im[FRAC+XIW-1:FRAC];

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_re  <= side[S_PR-1].mre * q2[WW];
      pr_im  <= side[S_PR-1].mim * q2[WW];
      eta_re <= side[S_OUT-1].sre ? XIW'(-mag_re) : mag_re;
      eta_im <= side[S_OUT-1].sim ? XIW'(-mag_im) : mag_im;
    end
  end

endmodule
